/* rtl/assert_macros.svh */
// Assertion helpers shared by the codec modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error(msg);

// When trig holds, cond must hold in the cycle after.
`define ASSERT_NEXT(label, clk, rst, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error(msg);

`endif

/* rtl/b64c_pkg.sv */
package b64c_pkg;

  // Register index, taken from paddr[2]
  localparam logic REG_DECODE_MODE     = 1'b0;
  localparam logic REG_BLOCKS_PER_LINE = 1'b1;

  localparam logic [7:0] BPL_RESET = 8'd18;

  localparam logic [7:0] CHAR_CR  = 8'h0D;
  localparam logic [7:0] CHAR_LF  = 8'h0A;
  localparam logic [7:0] CHAR_PAD = 8'h3D;

  localparam int unsigned MAX_RESULTS = 6;

  // One unit of work handed from front to back: up to six results
  typedef struct packed {
    logic [2:0]                   count;
    logic                         no_data;
    logic                         eos;
    logic [MAX_RESULTS-1:0][7:0]  bytes;
  } job_t;

  // Sextet value to alphabet character
  function automatic logic [7:0] b64_char(input logic [5:0] v);
    logic [7:0] v8;
    logic [7:0] r;
    v8 = {2'b00, v};
    if (v8 < 8'd26)      r = v8 + 8'd65;
    else if (v8 < 8'd52) r = v8 + 8'd71;
    else if (v8 < 8'd62) r = v8 - 8'd4;
    else if (v8 == 8'd62) r = 8'd43;
    else                 r = 8'd47;
    return r;
  endfunction

  // Character to {valid, sextet}
  function automatic logic [6:0] b64_sextet(input logic [7:0] c);
    logic [7:0] r;
    logic       ok;
    ok = 1'b1;
    r  = 8'd0;
    if (c >= 8'd65 && c <= 8'd90)       r = c - 8'd65;
    else if (c >= 8'd97 && c <= 8'd122) r = c - 8'd71;
    else if (c >= 8'd48 && c <= 8'd57)  r = c + 8'd4;
    else if (c == 8'd43)                r = 8'd62;
    else if (c == 8'd47)                r = 8'd63;
    else                                ok = 1'b0;
    return {ok, r[5:0]};
  endfunction

endpackage

/* rtl/b64c_front.sv */
`include "assert_macros.svh"

module b64c_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             clear,
  input  logic             decode_mode,
  input  logic [7:0]       blocks_per_line,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [7:0]       s_tdata,   // in_byte
  input  logic             s_tlast,   // stream_end
  input  logic             q_ready,
  output logic             push,
  output b64c_pkg::job_t   job
);

  logic [23:0] group_bits, group_bits_next;
  logic [1:0]  group_count, group_count_next;
  logic [7:0]  line_blocks, line_blocks_next;
  logic        accept;

  // encode signals
  logic [23:0] eb, aligned;
  logic [1:0]  ecnt;
  logic        e_full, wrote, brk, crlf;
  logic [7:0]  lb1;

  // decode signals
  logic [6:0]  sx;
  logic [23:0] dbits;
  logic        dfull;
  logic [1:0]  dcnt;

  assign s_tready = q_ready;
  assign accept   = s_tvalid & q_ready;
  assign push     = accept & (job.count != 3'd0);

  // Encode path: gather bytes, build a block and a line break
  always_comb begin
    eb     = {group_bits[15:0], s_tdata};
    ecnt   = group_count + 2'd1;
    e_full = (ecnt == 2'd3);
    wrote  = e_full | s_tlast;
    if (e_full)            aligned = eb;
    else if (ecnt == 2'd1) aligned = {eb[7:0], 16'h0000};
    else                   aligned = {eb[15:0], 8'h00};
    lb1  = line_blocks + {7'd0, wrote};
    brk  = (wrote && (lb1 >= blocks_per_line)) || s_tlast;
    crlf = brk && (lb1 != 8'd0);
  end

  // Decode path: gather sextets, full group or flush at stream end
  always_comb begin
    sx    = b64c_pkg::b64_sextet(s_tdata);
    dfull = sx[6] && (group_count == 2'd3);
    dbits = sx[6] ? {group_bits[17:0], sx[5:0]} : group_bits;
    if (!sx[6])     dcnt = group_count;
    else if (dfull) dcnt = 2'd0;
    else            dcnt = group_count + 2'd1;
  end

  // Job and next state
  always_comb begin
    job              = '0;
    group_bits_next  = group_bits;
    group_count_next = group_count;
    line_blocks_next = line_blocks;
    job.eos          = s_tlast;
    if (!decode_mode) begin
      if (wrote) begin
        job.bytes[0] = b64c_pkg::b64_char(aligned[23:18]);
        job.bytes[1] = b64c_pkg::b64_char(aligned[17:12]);
        job.bytes[2] = (ecnt != 2'd1) ? b64c_pkg::b64_char(aligned[11:6])
                                      : b64c_pkg::CHAR_PAD;
        job.bytes[3] = e_full ? b64c_pkg::b64_char(aligned[5:0]) : b64c_pkg::CHAR_PAD;
        job.bytes[4] = b64c_pkg::CHAR_CR;
        job.bytes[5] = b64c_pkg::CHAR_LF;
        job.count    = crlf ? 3'd6 : 3'd4;
      end
      if (e_full || s_tlast) begin
        group_bits_next  = '0;
        group_count_next = 2'd0;
      end else begin
        group_bits_next  = eb;
        group_count_next = ecnt;
      end
      line_blocks_next = brk ? 8'd0 : lb1;
    end else begin
      if (dfull) begin
        job.bytes[0] = dbits[23:16];
        job.bytes[1] = dbits[15:8];
        job.bytes[2] = dbits[7:0];
        job.count    = 3'd3;
      end else if (s_tlast) begin
        if (dcnt == 2'd3) begin
          job.bytes[0] = dbits[17:10];
          job.bytes[1] = dbits[9:2];
          job.count    = 3'd2;
        end else if (dcnt == 2'd2) begin
          job.bytes[0] = dbits[11:4];
          job.count    = 3'd1;
        end else begin
          // nothing left to give: bare end marker
          job.no_data = 1'b1;
          job.count   = 3'd1;
        end
      end
      group_bits_next  = dfull ? 24'd0 : dbits;
      group_count_next = dcnt;
    end
    if (s_tlast) begin
      group_bits_next  = '0;
      group_count_next = 2'd0;
      line_blocks_next = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      group_bits  <= '0;
      group_count <= 2'd0;
      line_blocks <= 8'd0;
    end else if (accept) begin
      group_bits  <= group_bits_next;
      group_count <= group_count_next;
      line_blocks <= line_blocks_next;
    end
  end

  // Encoder never holds a full group between items
  `ASSERT_ALWAYS(a_enc_group, clk, rst, decode_mode || (group_count != 2'd3), "enc group full")
  // A stream end leaves the gathering state empty
  `ASSERT_NEXT(a_end_clear, clk, rst, accept && s_tlast, group_count == 2'd0, "end not cleared")

endmodule

/* rtl/b64c_queue.sv */
`include "assert_macros.svh"

module b64c_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  b64c_pkg::job_t   push_job,
  output logic             in_ready,
  input  logic             pop,
  output logic             out_valid,
  output b64c_pkg::job_t   out_job
);

  b64c_pkg::job_t entries [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_job   = entries[rd_ptr];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_job;
  end

  `ASSERT_ALWAYS(a_q_level, clk, rst, count != 2'd3, "queue level out of range")
  `ASSERT_ALWAYS(a_q_pop, clk, rst, !pop || out_valid, "pop from empty queue")

endmodule

/* rtl/b64c_back.sv */
`include "assert_macros.svh"

module b64c_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  b64c_pkg::job_t   q_job,
  output logic             pop,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [7:0]       m_tdata,   // out_byte
  output logic             m_tuser,   // has_data
  output logic             m_tlast    // end_of_stream
);

  b64c_pkg::job_t cur;
  logic [2:0]     idx;
  logic           busy;
  logic           last;

  assign last     = (idx == cur.count - 3'd1);
  assign pop      = q_valid && (!busy || (m_tready && last));
  assign m_tvalid = busy;
  assign m_tdata  = cur.bytes[idx];
  assign m_tuser  = ~cur.no_data;
  assign m_tlast  = cur.eos & last;

  // Walk through the results of the current job
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= 3'd0;
    end else if (pop) begin
      busy <= 1'b1;
      idx  <= 3'd0;
    end else if (busy && m_tready) begin
      if (last) busy <= 1'b0;
      else      idx  <= idx + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) cur <= q_job;
  end

  `ASSERT_ALWAYS(a_job_count, clk, rst, !busy || (cur.count != 3'd0), "empty job in back")
  `ASSERT_ALWAYS(a_idx_range, clk, rst, !busy || (idx < cur.count), "result index past job")

endmodule

/* rtl/base64_stream_codec.sv */
// Base64 stream codec, encode or decode selected by register.
// With the back end idle, an accepted item is written into the two-entry queue and
// then loaded into the output serializer, whose register presents its first result.
// Throughput: one result per cycle while m_tready is high; an item gives as many
// results as its job holds (up to 6), sent by the single output serializer. Items with no result are not queued.
// Reset (rst, synchronous): encode mode, 18 blocks per line, group state cleared.
module base64_stream_codec (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // in_byte
  input  logic        s_tlast,   // stream_end
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // out_byte
  output logic        m_tuser,   // has_data
  output logic        m_tlast,   // end_of_stream
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic           decode_mode;
  logic [7:0]     blocks_per_line;
  logic           cfg_wr, mode_clear;
  logic           q_ready, q_push, q_valid, q_pop;
  b64c_pkg::job_t f_job, q_job;

  // Configuration registers
  assign pready     = 1'b1;
  assign cfg_wr     = psel & penable & pwrite & pready;
  assign mode_clear = cfg_wr && (paddr[2] == b64c_pkg::REG_DECODE_MODE);

  always_ff @(posedge clk) begin
    if (rst) begin
      decode_mode     <= 1'b0;
      blocks_per_line <= b64c_pkg::BPL_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == b64c_pkg::REG_DECODE_MODE) decode_mode     <= pwdata[0];
      else                                       blocks_per_line <= pwdata[7:0];
    end
  end

  always_comb begin
    if (paddr[2] == b64c_pkg::REG_DECODE_MODE) prdata = {31'd0, decode_mode};
    else                                       prdata = {24'd0, blocks_per_line};
  end

  b64c_front u_front (
    .clk             (clk),
    .rst             (rst),
    .clear           (mode_clear),
    .decode_mode     (decode_mode),
    .blocks_per_line (blocks_per_line),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .s_tlast         (s_tlast),
    .q_ready         (q_ready),
    .push            (q_push),
    .job             (f_job)
  );

  b64c_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_job  (f_job),
    .in_ready  (q_ready),
    .pop       (q_pop),
    .out_valid (q_valid),
    .out_job   (q_job)
  );

  b64c_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_job    (q_job),
    .pop      (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

/* tb/b64_codec_checker.sv */
`timescale 1ns / 100ps

// Watches the byte, character and register channels of the Base64 codec,
// predicts every output request and compares it field by field.
module b64_codec_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,   // in_byte
  input  logic        s_tlast,   // stream_end
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [7:0]  m_tdata,   // out_byte
  input  logic        m_tuser,   // has_data
  input  logic        m_tlast,   // end_of_stream
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  output int          errors,
  output int          pending
);

  typedef struct packed {
    logic [7:0] data;
    logic       has_data;
    logic       eos;
  } codec_out_t;

  localparam logic [8*64-1:0] ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  // shadow of the registers and of the group/line state
  logic        mode_dec;
  logic [7:0]  line_width;
  logic [23:0] grp_bits;
  logic [1:0]  grp_cnt;
  logic [7:0]  line_cnt;

  codec_out_t  predicted_bytes[$];
  codec_out_t  want;

  function automatic logic [7:0] char_of(input logic [5:0] v);
    return ALPHABET[8*(63-v) +: 8];
  endfunction

  // -1 for anything outside the alphabet
  function automatic int sextet_value(input logic [7:0] c);
    for (int i = 0; i < 64; i++) begin
      if (char_of(i[5:0]) == c) return i;
    end
    return -1;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    errors++;
    $display("%0t ns mismatch on %s: got 0x%0h, expected 0x%0h",
             $time, what, got, exp_val);
  endtask

  task automatic clear_group();
    grp_bits = '0;
    grp_cnt  = '0;
    line_cnt = '0;
  endtask

  task automatic put(input logic [7:0] d, input logic hd);
    codec_out_t r;
    r.data     = d;
    r.has_data = hd;
    r.eos      = 1'b0;
    predicted_bytes.push_back(r);
  endtask

  // four characters from 24 left-aligned bits, '=' for missing bytes
  task automatic put_block(input logic [23:0] bits, input int nbytes);
    put(char_of(bits[23:18]), 1'b1);
    put(char_of(bits[17:12]), 1'b1);
    put(nbytes > 1 ? char_of(bits[11:6]) : b64c_pkg::CHAR_PAD, 1'b1);
    put(nbytes > 2 ? char_of(bits[5:0]) : b64c_pkg::CHAR_PAD, 1'b1);
    line_cnt = line_cnt + 8'd1;
  endtask

  task automatic encode_byte(input logic [7:0] b, input logic last);
    logic wrote;
    wrote    = 1'b0;
    grp_bits = {grp_bits[15:0], b};
    grp_cnt  = grp_cnt + 2'd1;
    if (grp_cnt == 2'd3) begin
      put_block(grp_bits, 3);
      wrote    = 1'b1;
      grp_bits = '0;
      grp_cnt  = '0;
    end else if (last) begin
      put_block(grp_cnt == 2'd1 ? {grp_bits[7:0], 16'h0000} : {grp_bits[15:0], 8'h00},
                grp_cnt);
      wrote = 1'b1;
    end
    // line break once the line is full, and to close the last line
    if ((wrote && line_cnt >= line_width) || last) begin
      if (line_cnt != 8'd0) begin
        put(b64c_pkg::CHAR_CR, 1'b1);
        put(b64c_pkg::CHAR_LF, 1'b1);
      end
      line_cnt = '0;
    end
    if (last) begin
      predicted_bytes[predicted_bytes.size()-1].eos = 1'b1;
      clear_group();
    end
  endtask

  task automatic decode_char(input logic [7:0] c, input logic last);
    int          v;
    int          n0;
    logic [23:0] bits;
    n0 = predicted_bytes.size();
    v  = sextet_value(c);
    if (v >= 0) begin
      grp_bits = {grp_bits[17:0], v[5:0]};
      if (grp_cnt == 2'd3) begin
        put(grp_bits[23:16], 1'b1);
        put(grp_bits[15:8], 1'b1);
        put(grp_bits[7:0], 1'b1);
        grp_bits = '0;
        grp_cnt  = '0;
      end else begin
        grp_cnt = grp_cnt + 2'd1;
      end
    end
    if (last) begin
      // short group of n sextets flushes n-1 bytes
      if (grp_cnt != 2'd0) begin
        bits = grp_bits << (6 * (4 - grp_cnt));
        for (int k = 0; k + 1 < grp_cnt; k++) put(bits[23-8*k -: 8], 1'b1);
      end
      if (predicted_bytes.size() == n0) put(8'h00, 1'b0);
      predicted_bytes[predicted_bytes.size()-1].eos = 1'b1;
      clear_group();
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      mode_dec   = 1'b0;
      line_width = b64c_pkg::BPL_RESET;
      clear_group();
      predicted_bytes.delete();
      errors     = 0;
      pending   <= 0;
    end else begin
      // register access
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr[2] == b64c_pkg::REG_DECODE_MODE) begin
            mode_dec = pwdata[0];
            clear_group();
          end else begin
            line_width = pwdata[7:0];
          end
        end else if (paddr[2] == b64c_pkg::REG_DECODE_MODE) begin
          if (prdata !== {31'd0, mode_dec})
            report_mismatch("decode_mode read", prdata, {31'd0, mode_dec});
        end else if (prdata !== {24'd0, line_width}) begin
          report_mismatch("blocks_per_line read", prdata, {24'd0, line_width});
        end
      end
      // output side first: results of this edge belong to older requests
      if (m_tvalid && m_tready) begin
        if (predicted_bytes.size() == 0) begin
          report_mismatch("unexpected result", {22'd0, m_tlast, m_tuser, m_tdata}, 32'd0);
        end else begin
          want = predicted_bytes.pop_front();
          if (m_tdata !== want.data)
            report_mismatch("out_byte", {24'd0, m_tdata}, {24'd0, want.data});
          if (m_tuser !== want.has_data)
            report_mismatch("has_data", {31'd0, m_tuser}, {31'd0, want.has_data});
          if (m_tlast !== want.eos)
            report_mismatch("end_of_stream", {31'd0, m_tlast}, {31'd0, want.eos});
        end
      end
      if (s_tvalid && s_tready) begin
        if (mode_dec) decode_char(s_tdata, s_tlast);
        else          encode_byte(s_tdata, s_tlast);
      end
      pending <= predicted_bytes.size();
    end
  end

endmodule

/* tb/tb_base64_stream_codec.sv */
`timescale 1ns / 100ps

module tb_base64_stream_codec;

  localparam logic [8*64-1:0] ALPHA =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;
  logic        m_tuser;
  logic        m_tlast;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int errors;
  int pending;
  int items_sent;
  bit steady;    // no idling on either side
  bit hold_go;   // toggled to ask the receiver for a long hold-off
  bit dec_mode;

  always #5 clk = ~clk;

  base64_stream_codec dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  b64_codec_checker chk (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .errors(errors), .pending(pending)
  );

  initial begin
    #10_000_000;
    $display("tb_base64_stream_codec failed");
    $finish;
  end

  function automatic logic [7:0] alpha_char(input logic [5:0] v);
    return ALPHA[8*(63-v) +: 8];
  endfunction

  // mostly back to back, sometimes short gaps, rarely long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // receiver: random ready pattern, plus a long hold-off on request
  initial begin : rx_side
    int stall_left;
    int run_left;
    int r;
    bit seen;
    stall_left = 0;
    run_left   = 0;
    seen       = 1'b0;
    m_tready   = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_go != seen) begin
        seen       = hold_go;
        stall_left = 300;
        run_left   = 0;
      end
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else if (steady || run_left > 0) begin
        m_tready <= 1'b1;
        if (run_left > 0) run_left--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          m_tready <= 1'b1;
          run_left = $urandom_range(0, 11);
        end else if (r < 65) begin
          m_tready <= 1'b1;
          run_left = $urandom_range(20, 80);
        end else if (r < 92) begin
          m_tready <= 1'b0;
          stall_left = $urandom_range(0, 2);
        end else begin
          m_tready <= 1'b0;
          stall_left = $urandom_range(9, 39);
        end
      end
    end
  end

  // one request on the input side, returns at the accepting edge
  task automatic send(input logic [7:0] b, input logic last);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic send_text(input string txt, input logic close);
    for (int i = 0; i < txt.len(); i++) send(txt[i], close && i == txt.len() - 1);
  endtask

  // stop sending and wait until every predicted result is out, then let
  // the pipeline settle for items that produce nothing
  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic idx, input logic [31:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_mode(input bit dec);
    dec_mode = dec;
    apb_access(1'b1, b64c_pkg::REG_DECODE_MODE, {31'd0, dec});
  endtask

  task automatic set_line(input logic [7:0] blocks);
    apb_access(1'b1, b64c_pkg::REG_BLOCKS_PER_LINE, {24'd0, blocks});
  endtask

  task automatic enc_stream(input int len, input logic close);
    for (int i = 0; i < len; i++) send(8'($urandom_range(0, 255)), close && i == len - 1);
    items_sent += len;
  endtask

  // mostly well-formed text with random content, line breaks and padding;
  // some noise and truncated groups
  task automatic dec_stream(input logic close);
    logic [7:0] text[$];
    int nsx;
    int n;
    nsx = $urandom_range(1, 20);
    if (nsx % 4 == 1 && $urandom_range(0, 7) != 0) nsx++;
    if ($urandom_range(0, 9) == 0) begin
      n = $urandom_range(1, 5);
      for (int i = 0; i < n; i++) text.push_back(8'($urandom_range(0, 255)));
      nsx = 0;
    end else begin
      for (int i = 0; i < nsx; i++) begin
        if (i > 0 && i % 4 == 0 && $urandom_range(0, 4) == 0) begin
          text.push_back(b64c_pkg::CHAR_CR);
          text.push_back(b64c_pkg::CHAR_LF);
        end
        if ($urandom_range(0, 19) == 0) text.push_back(8'($urandom_range(0, 255)));
        text.push_back(alpha_char(6'($urandom_range(0, 63))));
      end
      if (nsx % 4 != 0 && $urandom_range(0, 3) != 0)
        repeat (4 - nsx % 4) text.push_back(b64c_pkg::CHAR_PAD);
    end
    if ($urandom_range(0, 2) == 0) begin
      text.push_back(b64c_pkg::CHAR_CR);
      text.push_back(b64c_pkg::CHAR_LF);
    end
    foreach (text[k]) send(text[k], close && k == text.size() - 1);
    items_sent += text.size();
  endtask

  initial begin : stim
    int phase;
    int nstreams;
    int r;
    logic close;
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    s_tlast    = 1'b0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    steady     = 1'b0;
    hold_go    = 1'b0;
    dec_mode   = 1'b0;
    items_sent = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset values of both registers
    apb_access(1'b0, b64c_pkg::REG_DECODE_MODE, '0);
    apb_access(1'b0, b64c_pkg::REG_BLOCKS_PER_LINE, '0);

    // encode: full group, one- and two-byte tails, one line per block
    set_line(8'd1);
    send(8'h00, 1'b0);
    send(8'hFF, 1'b0);
    send(8'h80, 1'b0);
    send(8'h01, 1'b1);
    send(8'hFE, 1'b0);
    send(8'h7F, 1'b1);
    drain();
    // zero line width: break after every block
    set_line(8'd0);
    send(8'h4D, 1'b0);
    send(8'h61, 1'b0);
    send(8'h6E, 1'b0);
    send(8'hA5, 1'b1);
    drain();
    // widest line, then lowered in the middle of it
    set_line(8'd255);
    enc_stream(6, 1'b0);
    drain();
    set_line(8'd1);
    enc_stream(3, 1'b0);
    send(8'h5A, 1'b1);
    // half group dropped by the mode change
    send(8'h11, 1'b0);
    send(8'h22, 1'b0);
    drain();
    set_mode(1'b1);

    // decode: full group, padded tail ending on a skipped character,
    // alphabet edges, bare end marker, characters just outside the alphabet
    send_text("TWFu", 1'b0);
    send_text("QQ==\r\n", 1'b1);
    send_text("/+9z", 1'b0);
    send_text("QUI", 1'b1);
    send_text("*", 1'b1);
    send(8'd44, 1'b0);
    send(8'd123, 1'b0);
    send(8'hFF, 1'b0);
    send(8'h00, 1'b0);
    send(8'd43, 1'b0);
    send(8'd122, 1'b1);

    // random phases; the long hold-off phase always runs
    items_sent = 0;
    phase      = 0;
    while (items_sent < 350 || phase < 3) begin
      drain();
      steady = 1'b0;
      if (phase == 2) begin
        set_mode(1'b0);
      end else if (phase == 0 || $urandom_range(0, 2) == 0) begin
        set_mode(1'($urandom_range(0, 1)));
      end
      if ($urandom_range(0, 1) == 0) begin
        r = $urandom_range(0, 9);
        if (r == 0)      set_line(8'd1);
        else if (r == 1) set_line(8'd255);
        else if (r == 2) set_line(8'($urandom_range(7, 40)));
        else             set_line(8'($urandom_range(1, 6)));
      end
      steady = ($urandom_range(0, 7) == 0);
      if (phase == 2) begin
        // receiver holds off while the sender keeps offering
        hold_go = ~hold_go;
        enc_stream(60, 1'b1);
      end
      nstreams = $urandom_range(1, 4);
      for (int s = 0; s < nstreams; s++) begin
        close = !(s == nstreams - 1 && $urandom_range(0, 3) == 0);
        if (dec_mode)                         dec_stream(close);
        else if ($urandom_range(0, 7) == 0)   enc_stream($urandom_range(30, 60), close);
        else                                  enc_stream($urandom_range(1, 12), close);
        if ($urandom_range(0, 5) == 0) drain();
      end
      phase++;
    end

    drain();
    repeat (20) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("tb_base64_stream_codec passed");
    end else begin
      $display("tb_base64_stream_codec failed");
    end
    $finish;
  end

endmodule
